FILE: src/newton_square_root_defines.svh
// Assertion macros used by the newton square root checker.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Check a condition in the same cycle as its trigger, clocked on clk_i, off in reset.
`define NSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger, clocked on clk_i, off in reset.
`define NSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/nsr_pkg.sv
// Field widths and constants shared by the newton square root block and its checker.
`default_nettype none

package nsr_pkg;

  localparam int RadicandW = 32;
  localparam int RootW     = 24;
  localparam int CountW    = 6;
  localparam int TolW      = 16;
  localparam logic [TolW-1:0] TolReset = TolW'(1);

  typedef logic [RadicandW-1:0] radicand_t;
  typedef logic [RootW-1:0]     root_t;
  typedef logic [CountW-1:0]    count_t;
  typedef logic [TolW-1:0]      tol_t;

endpackage

`default_nettype wire

FILE: src/newton_square_root.sv
// Newton-Raphson square root of an unsigned fixed-point radicand, one request at a time.
// The block takes one request at a time. A zero radicand goes straight to output. Any other
// radicand runs Newton steps x = (x + (n << FRAC_BITS) / x) / 2, starting at x = n, and each
// step runs a restoring divider that yields the quotient one bit per cycle, then the update
// state forms the new iterate and the decision state applies the stop rules. A new request
// is taken while the previous result still waits in the output register; the result register
// holds one answer, so a finished item waits only if that answer is not yet taken. The
// tolerance register (reset 1) is written through the cfg channel and read at every stop
// check, so write it only while no request is in flight.
`default_nettype none

module newton_square_root #(
  parameter int MAX_STEPS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration write channel
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire nsr_pkg::tol_t  cfg_data_i,
  // request channel
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire nsr_pkg::radicand_t radicand_i,
  // result channel
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output nsr_pkg::root_t      root_o,
  output nsr_pkg::count_t     step_count_o,
  output logic                converged_o
);

  import nsr_pkg::*;

  localparam int XW  = RadicandW;
  localparam int QW  = RadicandW + FRAC_BITS;
  localparam int DCW = $clog2(QW);
  localparam int SCW = $clog2(MAX_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_DEC,
    S_OUT
  } state_e;

  state_e          state_q, state_d;
  logic            out_valid_q, out_valid_d;
  tol_t            tol_q;

  logic [XW-1:0]   n_q, n_d;
  logic [XW-1:0]   x_q, x_d;
  logic [XW-1:0]   nx_q, nx_d;
  logic [XW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic [SCW-1:0]  steps_q, steps_d;
  logic            conv_q, conv_d;
  root_t           root_q, root_d;
  count_t          count_q, count_d;
  logic            conv_out_q, conv_out_d;

  logic [XW:0]     rem_sh;
  logic [XW:0]     rem_diff;
  logic            sub_ok;
  logic [QW:0]     sum;
  logic [XW-1:0]   mag;
  logic            out_free;
  logic [SCW+CountW-1:0] steps_ext;

  // Divider bit step, iterate update and step magnitude
  assign rem_sh    = {rem_q, quo_q[QW-1]};
  assign sub_ok    = rem_sh >= {1'b0, x_q};
  assign rem_diff  = rem_sh - {1'b0, x_q};
  assign sum       = {1'b0, quo_q} + (QW+1)'(x_q);
  assign mag       = (nx_q > x_q) ? (nx_q - x_q) : (x_q - nx_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign steps_ext = {{CountW{1'b0}}, steps_q};

  // Next-state and datapath logic
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    x_d        = x_q;
    nx_d       = nx_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dcnt_d     = dcnt_q;
    steps_d    = steps_q;
    conv_d     = conv_q;
    root_d     = root_q;
    count_d    = count_q;
    conv_out_d = conv_out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d     = radicand_i;
          x_d     = radicand_i;
          steps_d = '0;
          conv_d  = 1'b1;
          rem_d   = '0;
          quo_d   = {radicand_i, {FRAC_BITS{1'b0}}};
          dcnt_d  = DCW'(QW - 1);
          state_d = (radicand_i == '0) ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        rem_d = sub_ok ? rem_diff[XW-1:0] : rem_sh[XW-1:0];
        quo_d = {quo_q[QW-2:0], sub_ok};
        if (dcnt_q == '0) begin
          state_d = S_UPD;
        end else begin
          dcnt_d = dcnt_q - DCW'(1);
        end
      end
      S_UPD: begin
        nx_d    = sum[XW:1];
        steps_d = steps_q + SCW'(1);
        state_d = S_DEC;
      end
      S_DEC: begin
        if (mag < XW'(tol_q)) begin
          x_d     = nx_q;
          conv_d  = 1'b1;
          state_d = S_OUT;
        end else if (steps_q > SCW'(1) && nx_q >= x_q) begin
          // integer settling: keep the smaller iterate
          conv_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          x_d = nx_q;
          if (steps_q == SCW'(MAX_STEPS)) begin
            conv_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            rem_d   = '0;
            quo_d   = {n_q, {FRAC_BITS{1'b0}}};
            dcnt_d  = DCW'(QW - 1);
            state_d = S_DIV;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          root_d     = (x_q[XW-1:RootW] != '0) ? {RootW{1'b1}} : x_q[RootW-1:0];
          count_d    = steps_ext[CountW-1:0];
          conv_out_d = conv_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Raise the result when loaded, drop it once taken
    if (state_q == S_OUT && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state, result valid and tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tol_q       <= TolReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    x_q        <= x_d;
    nx_q       <= nx_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dcnt_q     <= dcnt_d;
    steps_q    <= steps_d;
    conv_q     <= conv_d;
    root_q     <= root_d;
    count_q    <= count_d;
    conv_out_q <= conv_out_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign step_count_o = count_q;
  assign converged_o  = conv_out_q;

endmodule

`default_nettype wire

FILE: src/nsr_checker.sv
// Port-level checker for the newton square root block, bound to the top level.
`default_nettype none
`include "newton_square_root_defines.svh"

module nsr_checker #(
  parameter int MAX_STEPS = 32
) (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_o,
  input wire                     out_valid_o,
  input wire                     out_ready_i,
  input wire nsr_pkg::root_t     root_o,
  input wire nsr_pkg::count_t    step_count_o,
  input wire                     converged_o
);

  import nsr_pkg::*;

  localparam count_t CapCount = CountW'(MAX_STEPS);

  logic out_stall;
  logic in_take;
  logic out_unconv;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_unconv = out_valid_o && !converged_o;

  // Hold a stalled result
  `NSR_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")
  `NSR_ASSERT_NEXT(a_root_stable, out_stall, $stable(root_o), "root changed while stalled")
  `NSR_ASSERT_NEXT(a_flag_stable, out_stall, $stable({step_count_o, converged_o}), "flags moved")

  // One request at a time: no request is taken right after another
  `NSR_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ready_o, "request taken while busy")

  // A result that missed convergence used every step
  `NSR_ASSERT_SAME(a_cap_count, out_unconv, step_count_o == CapCount, "unconverged below cap")

endmodule

bind newton_square_root nsr_checker #(.MAX_STEPS(MAX_STEPS)) u_nsr_checker (.*);

`default_nettype wire
